// ===== rtl/u8ds_pkg.sv =====
// u8ds_pkg: transaction types and character constants for the UTF-8 display sanitizer.
// No dependencies. Used by rtl/utf8_display_sanitizer.sv.

package u8ds_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  localparam logic [7:0]  QMARK      = 8'h3F;
  localparam logic [7:0]  LEAD2_MIN  = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX  = 8'hDF;
  localparam logic [7:0]  LEAD3_MIN  = 8'hE0;
  localparam logic [7:0]  LEAD3_MAX  = 8'hEF;
  localparam logic [7:0]  LEAD4_MIN  = 8'hF0;
  localparam logic [7:0]  LEAD4_MAX  = 8'hF4;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;
  localparam logic [20:0] MIN_3BYTE  = 21'h000800;
  localparam logic [20:0] MIN_4BYTE  = 21'h010000;

  // Maximum results one input byte can cause.
  localparam int unsigned MAX_RES = 4;

endpackage

// ===== rtl/utf8_display_sanitizer.sv =====
// utf8_display_sanitizer: streaming UTF-8 decoder/validator that replaces bad
// or non-displayable sequences with '?'. Depends on u8ds_pkg.

//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in_     | input     | in_valid / in_ready     | u8ds_pkg::in_item_t  (data_byte, final_byte)
//  out_    | output    | out_valid / out_ready   | u8ds_pkg::out_item_t (out_byte, run_last, text_end)
//
// Flow: a byte is registered on acceptance, then decoded combinationally into a
//   4-slot result buffer. Bytes causing 0 or 1 results flow at one per cycle while
//   out_ready stays high; a byte causing more results holds the decoder until
//   the buffer drains to its last result through its single output slot.
// Reset: rst_n, synchronous, active low; clears the decoder to "no sequence
//   open" and empties the input register and result buffer.
// Stalls: out_ready low freezes the buffer; in_ready stays high while the input
//   register is empty or its byte is moving into the buffer this cycle.

module utf8_display_sanitizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  u8ds_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output u8ds_pkg::out_item_t out_item
);

  // Control/format code points shown as a single '?'.
  function automatic logic unsafe_cp(input logic [20:0] cp);
    unsafe_cp = (cp <= 21'h1F) ||
                (cp >= 21'h7F   && cp <= 21'h9F)   ||
                (cp == 21'h061C) ||
                (cp >= 21'h200B && cp <= 21'h200F) ||
                (cp >= 21'h2028 && cp <= 21'h202E) ||
                (cp >= 21'h2060 && cp <= 21'h2069) ||
                (cp == 21'hFEFF);
  endfunction

  // ---------------- input register ----------------
  logic                in_v_r;
  u8ds_pkg::in_item_t  in_item_r;

  // ---------------- decoder state -----------------
  logic [1:0]  exp_r, exp_nxt;          // continuation bytes still needed
  logic [1:0]  held_cnt_r, held_cnt_nxt; // bytes of open sequence buffered
  logic [20:0] cv_r, cv_nxt;            // code point so far
  logic [7:0]  held_r   [3];            // no reset: read only once written
  logic [7:0]  held_nxt [3];

  // ---------------- result buffer -----------------
  // Slot 0 drives the output port; the rest shift down as results leave.
  u8ds_pkg::out_item_t ob_r [u8ds_pkg::MAX_RES];
  logic [2:0]          ob_cnt_r;

  u8ds_pkg::out_item_t res  [u8ds_pkg::MAX_RES];
  logic [7:0]          slot_byte [u8ds_pkg::MAX_RES];
  logic [2:0]          n_res;
  logic                load;
  logic                out_fire;

  assign out_valid = (ob_cnt_r != 3'd0);
  assign out_item  = ob_r[0];
  assign out_fire  = out_valid && out_ready;

  // The held byte moves into the buffer once the buffer is empty or its last
  // result leaves this cycle.
  assign load     = in_v_r && ((ob_cnt_r == 3'd0) || ((ob_cnt_r == 3'd1) && out_ready));
  assign in_ready = !in_v_r || load;

  // ---------------- decode ----------------
  always_comb begin
    logic [7:0]  b;
    logic        fin;
    logic        do_lead;
    logic        bad;
    logic [20:0] v;

    b            = in_item_r.data_byte;
    fin          = in_item_r.final_byte;
    exp_nxt      = exp_r;
    held_cnt_nxt = held_cnt_r;
    cv_nxt       = cv_r;
    do_lead      = 1'b0;
    bad          = 1'b0;
    v            = {cv_r[14:0], b[5:0]};
    n_res        = 3'd0;
    for (int i = 0; i < 3; i++) held_nxt[i] = held_r[i];
    for (int k = 0; k < u8ds_pkg::MAX_RES; k++) slot_byte[k] = u8ds_pkg::QMARK;

    if ((exp_r == 2'd0) || (held_cnt_r == 2'd0)) begin
      // No sequence open: byte is a fresh lead.
      exp_nxt      = 2'd0;
      held_cnt_nxt = 2'd0;
      cv_nxt       = '0;
      do_lead      = 1'b1;
    end else if (b[7:6] != 2'b10) begin
      // Sequence broken: '?' per buffered byte, then restart on this byte.
      for (int i = 0; i < 3; i++) begin
        if ((2'(i) < held_cnt_r) && (n_res < 3'd4)) begin
          slot_byte[n_res[1:0]] = u8ds_pkg::QMARK;
          n_res = n_res + 3'd1;
        end
      end
      exp_nxt      = 2'd0;
      held_cnt_nxt = 2'd0;
      cv_nxt       = '0;
      do_lead      = 1'b1;
    end else if (exp_r == 2'd1) begin
      // Last continuation byte: validate the complete code point.
      bad = ((held_cnt_r == 2'd2) && (v < u8ds_pkg::MIN_3BYTE)) ||
            ((held_cnt_r == 2'd3) && (v < u8ds_pkg::MIN_4BYTE)) ||
            (v > u8ds_pkg::CP_MAX) ||
            ((v >= u8ds_pkg::SURR_LO) && (v <= u8ds_pkg::SURR_HI));
      if (bad) begin
        for (int i = 0; i < 4; i++) begin
          if ((2'(i) <= held_cnt_r) && (n_res < 3'd4)) begin
            slot_byte[n_res[1:0]] = u8ds_pkg::QMARK;
            n_res = n_res + 3'd1;
          end
        end
      end else if (unsafe_cp(v)) begin
        slot_byte[0] = u8ds_pkg::QMARK;
        n_res        = 3'd1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if ((2'(i) < held_cnt_r) && (n_res < 3'd4)) begin
            slot_byte[n_res[1:0]] = held_r[i];
            n_res = n_res + 3'd1;
          end
        end
        if (n_res < 3'd4) begin
          slot_byte[n_res[1:0]] = b;
          n_res = n_res + 3'd1;
        end
      end
      exp_nxt      = 2'd0;
      held_cnt_nxt = 2'd0;
      cv_nxt       = '0;
    end else begin
      // More continuation bytes to come: buffer this one.
      for (int i = 0; i < 3; i++) begin
        if (held_cnt_r == 2'(i)) held_nxt[i] = b;
      end
      cv_nxt       = v;
      held_cnt_nxt = held_cnt_r + 2'd1;
      exp_nxt      = exp_r - 2'd1;
    end

    if (do_lead) begin
      if (!b[7]) begin
        if (n_res < 3'd4) begin
          slot_byte[n_res[1:0]] = unsafe_cp({13'd0, b}) ? u8ds_pkg::QMARK : b;
          n_res = n_res + 3'd1;
        end
      end else if ((b >= u8ds_pkg::LEAD2_MIN) && (b <= u8ds_pkg::LEAD2_MAX)) begin
        cv_nxt       = {16'd0, b[4:0]};
        exp_nxt      = 2'd1;
        held_nxt[0]  = b;
        held_cnt_nxt = 2'd1;
      end else if ((b >= u8ds_pkg::LEAD3_MIN) && (b <= u8ds_pkg::LEAD3_MAX)) begin
        cv_nxt       = {17'd0, b[3:0]};
        exp_nxt      = 2'd2;
        held_nxt[0]  = b;
        held_cnt_nxt = 2'd1;
      end else if ((b >= u8ds_pkg::LEAD4_MIN) && (b <= u8ds_pkg::LEAD4_MAX)) begin
        cv_nxt       = {18'd0, b[2:0]};
        exp_nxt      = 2'd3;
        held_nxt[0]  = b;
        held_cnt_nxt = 2'd1;
      end else if (n_res < 3'd4) begin
        // Bad lead byte.
        slot_byte[n_res[1:0]] = u8ds_pkg::QMARK;
        n_res = n_res + 3'd1;
      end
    end

    if (fin) begin
      // Text ends inside a sequence: '?' per buffered byte.
      if (exp_nxt != 2'd0) begin
        for (int i = 0; i < 3; i++) begin
          if ((2'(i) < held_cnt_nxt) && (n_res < 3'd4)) begin
            slot_byte[n_res[1:0]] = u8ds_pkg::QMARK;
            n_res = n_res + 3'd1;
          end
        end
      end
      exp_nxt      = 2'd0;
      held_cnt_nxt = 2'd0;
      cv_nxt       = '0;
    end

    for (int k = 0; k < u8ds_pkg::MAX_RES; k++) begin
      res[k].out_byte = slot_byte[k];
      res[k].run_last = (n_res == 3'(k + 1));
      res[k].text_end = (n_res == 3'(k + 1)) && fin;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      exp_r      <= 2'd0;
      held_cnt_r <= 2'd0;
      cv_r       <= '0;
      ob_cnt_r   <= 3'd0;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      if (load) begin
        exp_r      <= exp_nxt;
        held_cnt_r <= held_cnt_nxt;
        cv_r       <= cv_nxt;
        ob_cnt_r   <= n_res;
      end else if (out_fire) begin
        ob_cnt_r   <= ob_cnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_item_r <= in_item;
    if (load) begin
      for (int i = 0; i < 3; i++) held_r[i] <= held_nxt[i];
      for (int k = 0; k < u8ds_pkg::MAX_RES; k++) ob_r[k] <= res[k];
    end else if (out_fire) begin
      for (int k = 0; k < u8ds_pkg::MAX_RES - 1; k++) ob_r[k] <= ob_r[k + 1];
    end
  end

endmodule
